// ===== src/rtp_hp_pkg.sv =====
// ============================================================================
// RTP header parser - shared package
// Phase, record and status codes, the result record and queue constants.
// ============================================================================
package rtp_hp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam int unsigned HEADER_BYTES     = 12;
    localparam int unsigned EXT_PREFIX_BYTES = 4;
    localparam int unsigned RTP_VERSION      = 2;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_CSRC    = 3'd1,
        PH_EXTPRE  = 3'd2,
        PH_EXTBODY = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_CSRC      = 3'd1,
        KIND_EXTENSION = 3'd2,
        KIND_PAYLOAD   = 3'd3,
        KIND_SUMMARY   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_CSRC_TRUNC  = 3'd2,
        ST_EXT_TRUNC   = 3'd3,
        ST_PAD_LARGE   = 3'd4,
        ST_TOO_LONG    = 3'd5,
        ST_BAD_VERSION = 3'd6
    } status_t;

    typedef struct packed {
        kind_t        record_kind;
        logic [1:0]   version_field;
        logic         marker_flag;
        logic [6:0]   payload_kind;
        logic [15:0]  sequence_number;
        logic [31:0]  time_stamp;
        logic [31:0]  sync_source;
        logic [31:0]  data_word;
        logic [7:0]   padding_count;
        logic [15:0]  payload_length;
        status_t      status_code;
        logic         step_last;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

// ===== src/rtp_hp_if.sv =====
// ============================================================================
// RTP header parser - channel interfaces
// Valid/ready channels for packet bytes in and parsed records out.
// ============================================================================
interface rtp_hp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, data_byte, end_of_packet, input ready);
    modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface rtp_hp_rec_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [1:0]  version_field;
    logic        marker_flag;
    logic [6:0]  payload_kind;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] sync_source;
    logic [31:0] data_word;
    logic [7:0]  padding_count;
    logic [15:0] payload_length;
    logic [2:0]  status_code;
    logic        step_last;

    modport source (output valid, record_kind, version_field, marker_flag, payload_kind,
                    sequence_number, time_stamp, sync_source, data_word, padding_count,
                    payload_length, status_code, step_last, input ready);
    modport sink   (input valid, record_kind, version_field, marker_flag, payload_kind,
                    sequence_number, time_stamp, sync_source, data_word, padding_count,
                    payload_length, status_code, step_last, output ready);
endinterface

// ===== src/rtp_hp_parse.sv =====
// ============================================================================
// RTP header parser - parse engine
// Holds the per-packet parse state and turns one byte into up to two records.
// ============================================================================
module rtp_hp_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              end_of_packet,
    output rtp_hp_pkg::push_t push
);

    localparam logic [15:0] MaxBytes  = 16'(rtp_hp_pkg::MAX_PACKET_BYTES);
    localparam logic [15:0] HdrBytes  = 16'(rtp_hp_pkg::HEADER_BYTES);
    localparam logic [15:0] HdrLast   = 16'(rtp_hp_pkg::HEADER_BYTES - 1);
    localparam logic [17:0] ExtPrefix = 18'(rtp_hp_pkg::EXT_PREFIX_BYTES);
    localparam logic [1:0]  Version   = 2'(rtp_hp_pkg::RTP_VERSION);

    logic [15:0]         pos_reg,    pos_next;
    logic [7:0]          fhb_reg,    fhb_next;
    logic [7:0]          shb_reg,    shb_next;
    logic [15:0]         seq_reg,    seq_next;
    logic [31:0]         ts_reg,     ts_next;
    logic [31:0]         ssrc_reg,   ssrc_next;
    logic [31:0]         wa_reg,     wa_next;
    logic [3:0]          csrc_reg,   csrc_next;
    logic [17:0]         extrem_reg, extrem_next;
    logic [15:0]         poff_reg,   poff_next;
    rtp_hp_pkg::phase_t  phase_reg,  phase_next;

    logic        too_long;
    logic [15:0] pos_inc;
    logic [15:0] ext_words;
    logic        data_valid;
    logic [15:0] avail;
    logic [7:0]  pad;
    rtp_hp_pkg::rec_t data_rec;
    rtp_hp_pkg::rec_t summ_rec;

    assign too_long  = (pos_reg >= MaxBytes);
    assign pos_inc   = pos_reg + 16'd1;
    assign ext_words = {wa_reg[7:0], data_byte};

    // next state: update for one byte
    always_comb
    begin
        pos_next    = pos_reg;
        fhb_next    = fhb_reg;
        shb_next    = shb_reg;
        seq_next    = seq_reg;
        ts_next     = ts_reg;
        ssrc_next   = ssrc_reg;
        wa_next     = wa_reg;
        csrc_next   = csrc_reg;
        extrem_next = extrem_reg;
        poff_next   = poff_reg;
        phase_next  = phase_reg;
        if (too_long)
        begin
            phase_next = rtp_hp_pkg::PH_DROP;
        end
        else
        begin
            pos_next = pos_inc;
            case (phase_reg)
                rtp_hp_pkg::PH_FIXED:
                begin
                    if (pos_reg == 16'd0)
                        fhb_next = data_byte;
                    else if (pos_reg == 16'd1)
                        shb_next = data_byte;
                    else if (pos_reg < 16'd4)
                        seq_next = {seq_reg[7:0], data_byte};
                    else if (pos_reg < 16'd8)
                        ts_next = {ts_reg[23:0], data_byte};
                    else
                        ssrc_next = {ssrc_reg[23:0], data_byte};
                    if (pos_reg == HdrLast)
                    begin
                        csrc_next = fhb_reg[3:0];
                        wa_next   = '0;
                        if (fhb_reg[3:0] != 4'd0)
                        begin
                            phase_next = rtp_hp_pkg::PH_CSRC;
                        end
                        else if (fhb_reg[4])
                        begin
                            phase_next  = rtp_hp_pkg::PH_EXTPRE;
                            extrem_next = ExtPrefix;
                        end
                        else
                        begin
                            phase_next = rtp_hp_pkg::PH_PAYLOAD;
                            poff_next  = pos_inc;
                        end
                    end
                end
                rtp_hp_pkg::PH_CSRC:
                begin
                    wa_next = {wa_reg[23:0], data_byte};
                    if (pos_reg[1:0] == 2'd3)
                    begin
                        wa_next   = '0;
                        csrc_next = csrc_reg - 4'd1;
                        if (csrc_reg == 4'd1)
                        begin
                            if (fhb_reg[4])
                            begin
                                phase_next  = rtp_hp_pkg::PH_EXTPRE;
                                extrem_next = ExtPrefix;
                            end
                            else
                            begin
                                phase_next = rtp_hp_pkg::PH_PAYLOAD;
                                poff_next  = pos_inc;
                            end
                        end
                    end
                end
                rtp_hp_pkg::PH_EXTPRE:
                begin
                    wa_next     = {wa_reg[23:0], data_byte};
                    extrem_next = extrem_reg - 18'd1;
                    if (extrem_reg == 18'd1)
                    begin
                        extrem_next = {ext_words, 2'b00};
                        wa_next     = '0;
                        if (ext_words == 16'd0)
                        begin
                            phase_next = rtp_hp_pkg::PH_PAYLOAD;
                            poff_next  = pos_inc;
                        end
                        else
                        begin
                            phase_next = rtp_hp_pkg::PH_EXTBODY;
                        end
                    end
                end
                rtp_hp_pkg::PH_EXTBODY:
                begin
                    extrem_next = extrem_reg - 18'd1;
                    if (extrem_reg == 18'd1)
                    begin
                        phase_next = rtp_hp_pkg::PH_PAYLOAD;
                        poff_next  = pos_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs: data record and end summary
    always_comb
    begin
        data_rec   = '0;
        data_valid = 1'b0;
        if (!too_long)
        begin
            case (phase_reg)
                rtp_hp_pkg::PH_FIXED:
                begin
                    data_valid                = (pos_reg == HdrLast);
                    data_rec.record_kind      = rtp_hp_pkg::KIND_HEADER;
                    data_rec.version_field    = fhb_next[7:6];
                    data_rec.marker_flag      = shb_next[7];
                    data_rec.payload_kind     = shb_next[6:0];
                    data_rec.sequence_number  = seq_next;
                    data_rec.time_stamp       = ts_next;
                    data_rec.sync_source      = ssrc_next;
                end
                rtp_hp_pkg::PH_CSRC:
                begin
                    data_valid           = (pos_reg[1:0] == 2'd3);
                    data_rec.record_kind = rtp_hp_pkg::KIND_CSRC;
                    data_rec.data_word   = {wa_reg[23:0], data_byte};
                end
                rtp_hp_pkg::PH_EXTPRE, rtp_hp_pkg::PH_EXTBODY:
                begin
                    data_valid           = 1'b1;
                    data_rec.record_kind = rtp_hp_pkg::KIND_EXTENSION;
                    data_rec.data_word   = {24'd0, data_byte};
                end
                rtp_hp_pkg::PH_PAYLOAD:
                begin
                    data_valid           = 1'b1;
                    data_rec.record_kind = rtp_hp_pkg::KIND_PAYLOAD;
                    data_rec.data_word   = {24'd0, data_byte};
                end
                default:
                begin
                end
            endcase
        end
        data_rec.step_last = !end_of_packet;

        avail = (pos_next >= poff_next) ? (pos_next - poff_next) : 16'd0;
        pad   = fhb_next[5] ? data_byte : 8'd0;

        summ_rec                  = '0;
        summ_rec.record_kind      = rtp_hp_pkg::KIND_SUMMARY;
        summ_rec.version_field    = fhb_next[7:6];
        summ_rec.marker_flag      = shb_next[7];
        summ_rec.payload_kind     = shb_next[6:0];
        summ_rec.sequence_number  = seq_next;
        summ_rec.time_stamp       = ts_next;
        summ_rec.sync_source      = ssrc_next;
        summ_rec.padding_count    = pad;
        summ_rec.step_last        = 1'b1;
        case (phase_next)
            rtp_hp_pkg::PH_FIXED:
            begin
                summ_rec.status_code   = rtp_hp_pkg::ST_SHORT;
                summ_rec.padding_count = 8'd0;
            end
            rtp_hp_pkg::PH_CSRC:
                summ_rec.status_code = rtp_hp_pkg::ST_CSRC_TRUNC;
            rtp_hp_pkg::PH_EXTPRE, rtp_hp_pkg::PH_EXTBODY:
                summ_rec.status_code = rtp_hp_pkg::ST_EXT_TRUNC;
            rtp_hp_pkg::PH_PAYLOAD:
            begin
                if ({8'd0, pad} > avail)
                begin
                    summ_rec.status_code = rtp_hp_pkg::ST_PAD_LARGE;
                end
                else
                begin
                    summ_rec.payload_length = avail - {8'd0, pad};
                    summ_rec.status_code    = (fhb_next[7:6] == Version) ?
                                              rtp_hp_pkg::ST_OK : rtp_hp_pkg::ST_BAD_VERSION;
                end
            end
            default:
                summ_rec.status_code = rtp_hp_pkg::ST_TOO_LONG;
        endcase

        push = '0;
        if (step)
        begin
            push.count = {1'b0, data_valid} + {1'b0, end_of_packet};
            push.rec0  = data_valid ? data_rec : summ_rec;
            push.rec1  = summ_rec;
        end
    end

    // commit byte; return to reset values after the last byte of a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fhb_reg    <= '0;
            shb_reg    <= '0;
            seq_reg    <= '0;
            ts_reg     <= '0;
            ssrc_reg   <= '0;
            wa_reg     <= '0;
            csrc_reg   <= '0;
            extrem_reg <= '0;
            poff_reg   <= HdrBytes;
            phase_reg  <= rtp_hp_pkg::PH_FIXED;
        end
        else if (step)
        begin
            if (end_of_packet)
            begin
                pos_reg    <= '0;
                fhb_reg    <= '0;
                shb_reg    <= '0;
                seq_reg    <= '0;
                ts_reg     <= '0;
                ssrc_reg   <= '0;
                wa_reg     <= '0;
                csrc_reg   <= '0;
                extrem_reg <= '0;
                poff_reg   <= HdrBytes;
                phase_reg  <= rtp_hp_pkg::PH_FIXED;
            end
            else
            begin
                pos_reg    <= pos_next;
                fhb_reg    <= fhb_next;
                shb_reg    <= shb_next;
                seq_reg    <= seq_next;
                ts_reg     <= ts_next;
                ssrc_reg   <= ssrc_next;
                wa_reg     <= wa_next;
                csrc_reg   <= csrc_next;
                extrem_reg <= extrem_next;
                poff_reg   <= poff_next;
                phase_reg  <= phase_next;
            end
        end
    end

endmodule

// ===== src/rtp_hp_outq.sv =====
// ============================================================================
// RTP header parser - result queue
// Small record queue: takes up to two records a cycle, gives one a beat.
// ============================================================================
module rtp_hp_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtp_hp_pkg::push_t push,
    input  logic              pop,
    output rtp_hp_pkg::rec_t  head,
    output logic              head_valid,
    output logic              space
);

    localparam int unsigned PW = rtp_hp_pkg::QUEUE_PTR_W;
    localparam int unsigned CW = rtp_hp_pkg::QUEUE_CNT_W;
    localparam logic [CW-1:0] RoomLimit = CW'(rtp_hp_pkg::QUEUE_DEPTH - 2);

    rtp_hp_pkg::rec_t bank_reg [rtp_hp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] wr_second;

    assign head       = bank_reg[rd_reg];
    assign head_valid = (cnt_reg != '0);
    assign space      = (cnt_reg <= RoomLimit);
    assign wr_second  = wr_reg + PW'(1);

    always_comb
    begin
        wr_next  = wr_reg + PW'(push.count);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            bank_reg[wr_reg] <= push.rec0;
        if (push.count == 2'd2)
            bank_reg[wr_second] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/rtp_header_parser.sv =====
// ============================================================================
// RTP header parser - top level
// Parses an RTP byte stream into header, CSRC, extension, payload and
// end-of-packet summary records.
// ============================================================================
// Usage:
//   pkt_in  carries one packet byte a beat, end_of_packet set on the last one.
//   rec_out carries one record a beat: the fixed header after byte twelve,
//   each CSRC word, each extension byte, each payload byte (padding
//   included), and a summary after the last byte; step_last marks the last
//   record a byte causes.
//   Each byte is registered in the byte register, and its records in the queue.
//   Throughput: one byte a cycle; the byte register feeds the parse engine
//   every cycle while the four-entry record queue has room for two records.
//   The last byte of a packet can yield two records, so the output side sets
//   the sustained rate when packets are very short.
//   Reset clears the parse state and empties the byte register and the
//   queue; the first byte may be offered in the first cycle after reset.
//   A stalled receiver fills the queue; pkt_in.ready drops once it cannot
//   take two more records, and no record is lost.
// ============================================================================
module rtp_header_parser
(
    input  logic         clk,
    input  logic         rst_n,
    rtp_hp_byte_if.sink  pkt_in,
    rtp_hp_rec_if.source rec_out
);

    logic       full_reg;
    logic [7:0] byte_reg;
    logic       eop_reg;
    logic       step;
    logic       space;
    logic       pop;
    logic       head_valid;
    rtp_hp_pkg::push_t push;
    rtp_hp_pkg::rec_t  head;

    assign step         = full_reg && space;
    assign pkt_in.ready = !full_reg || space;
    assign pop          = head_valid && rec_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (pkt_in.ready)
            full_reg <= pkt_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pkt_in.ready && pkt_in.valid)
        begin
            byte_reg <= pkt_in.data_byte;
            eop_reg  <= pkt_in.end_of_packet;
        end
    end

    rtp_hp_parse u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (byte_reg),
        .end_of_packet (eop_reg),
        .push          (push)
    );

    rtp_hp_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .space      (space)
    );

    assign rec_out.valid           = head_valid;
    assign rec_out.record_kind     = head.record_kind;
    assign rec_out.version_field   = head.version_field;
    assign rec_out.marker_flag     = head.marker_flag;
    assign rec_out.payload_kind    = head.payload_kind;
    assign rec_out.sequence_number = head.sequence_number;
    assign rec_out.time_stamp      = head.time_stamp;
    assign rec_out.sync_source     = head.sync_source;
    assign rec_out.data_word       = head.data_word;
    assign rec_out.padding_count   = head.padding_count;
    assign rec_out.payload_length  = head.payload_length;
    assign rec_out.status_code     = head.status_code;
    assign rec_out.step_last       = head.step_last;

endmodule

// ===== src/rtp_hp_checker.sv =====
// ============================================================================
// RTP header parser - port checker
// Checks record channel behaviour seen at the top-level ports.
// ============================================================================
module rtp_hp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  record_kind,
    input logic [31:0] data_word,
    input logic [7:0]  padding_count,
    input logic [15:0] payload_length,
    input logic [2:0]  status_code,
    input logic        step_last
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("record beat dropped while stalled");

    a_hold_beat : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(record_kind) && $stable(data_word)
                                    && $stable(status_code))
        else $error("record beat changed while stalled");

    a_summary_last : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == rtp_hp_pkg::KIND_SUMMARY |-> step_last)
        else $error("summary record not last of its byte");

    a_summary_only : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind != rtp_hp_pkg::KIND_SUMMARY
        |-> status_code == 3'd0 && payload_length == 16'd0 && padding_count == 8'd0)
        else $error("summary fields set on a data record");

endmodule

bind rtp_header_parser rtp_hp_checker u_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rec_out.valid),
    .out_ready      (rec_out.ready),
    .record_kind    (rec_out.record_kind),
    .data_word      (rec_out.data_word),
    .padding_count  (rec_out.padding_count),
    .payload_length (rec_out.payload_length),
    .status_code    (rec_out.status_code),
    .step_last      (rec_out.step_last)
);
